@@ hdl/bmp_pkg.sv @@
package bmp_pkg;

  localparam int unsigned NW   = 20;  // n and k
  localparam int unsigned MW   = 31;  // modulus and residues
  localparam int unsigned SW   = 5;   // normalizing shift
  localparam int unsigned MUW  = 33;  // Barrett reciprocal floor(2^62 / M)
  localparam int unsigned DCW  = 6;   // reciprocal step counter

  localparam logic [MW-1:0]  MODULUS_RESET = 31'd1000000007;
  localparam logic [23:0]    MAX_N         = 24'd1048575;
  // The reciprocal takes one quotient bit per step over a 63-bit dividend.
  localparam logic [DCW-1:0] DIV_LAST      = 6'd62;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_NORM,
    ST_DIV,
    ST_FACT_INIT,
    ST_FACT_MUL,
    ST_FACT_WAIT,
    ST_DENOM_MUL,
    ST_DENOM_WAIT,
    ST_POW,
    ST_ACC_WAIT,
    ST_SQ_MUL,
    ST_SQ_WAIT,
    ST_FINAL_MUL,
    ST_FINAL_WAIT,
    ST_FINISH
  } state_e;

  typedef enum logic [2:0] {
    MUL_FACT,
    MUL_DENOM,
    MUL_ACC,
    MUL_SQ,
    MUL_FINAL
  } mul_op_e;

  typedef struct packed {
    logic    in_ready;
    logic    latch_in;
    logic    load_err;
    logic    norm_init;
    logic    norm_step;
    logic    div_step;
    logic    fact_init;
    logic    mul_start;
    logic    mul_wb;
    mul_op_e mul_op;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic k_gt_n;
    logic bad_query;
    logic mnorm_top;
    logic div_last;
    logic n_zero;
    logic i_last;
    logic mul_busy;
    logic mul_done;
    logic exp_zero;
    logic exp_lsb;
    logic out_free;
  } sts_t;

endpackage

@@ hdl/bmp_ctrl.sv @@
module bmp_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  bmp_pkg::sts_t sts_i,
  output bmp_pkg::cmd_t cmd_o
);

  bmp_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bmp_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bmp_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = bmp_pkg::ST_CHECK;
      end
      bmp_pkg::ST_CHECK: begin
        if (sts_i.k_gt_n || sts_i.bad_query) state_d = bmp_pkg::ST_FINISH;
        else state_d = bmp_pkg::ST_NORM;
      end
      bmp_pkg::ST_NORM: begin
        if (sts_i.mnorm_top) state_d = bmp_pkg::ST_DIV;
      end
      bmp_pkg::ST_DIV: begin
        if (sts_i.div_last) state_d = bmp_pkg::ST_FACT_INIT;
      end
      bmp_pkg::ST_FACT_INIT: begin
        if (sts_i.n_zero) state_d = bmp_pkg::ST_DENOM_MUL;
        else state_d = bmp_pkg::ST_FACT_MUL;
      end
      bmp_pkg::ST_FACT_MUL: state_d = bmp_pkg::ST_FACT_WAIT;
      bmp_pkg::ST_FACT_WAIT: begin
        if (sts_i.mul_done) begin
          if (sts_i.i_last) state_d = bmp_pkg::ST_DENOM_MUL;
          else state_d = bmp_pkg::ST_FACT_MUL;
        end
      end
      bmp_pkg::ST_DENOM_MUL: state_d = bmp_pkg::ST_DENOM_WAIT;
      bmp_pkg::ST_DENOM_WAIT: begin
        if (sts_i.mul_done) state_d = bmp_pkg::ST_POW;
      end
      bmp_pkg::ST_POW: begin
        if (sts_i.exp_zero) state_d = bmp_pkg::ST_FINAL_MUL;
        else if (sts_i.exp_lsb) state_d = bmp_pkg::ST_ACC_WAIT;
        else state_d = bmp_pkg::ST_SQ_MUL;
      end
      bmp_pkg::ST_ACC_WAIT: begin
        if (sts_i.mul_done) state_d = bmp_pkg::ST_SQ_MUL;
      end
      bmp_pkg::ST_SQ_MUL: state_d = bmp_pkg::ST_SQ_WAIT;
      bmp_pkg::ST_SQ_WAIT: begin
        if (sts_i.mul_done) state_d = bmp_pkg::ST_POW;
      end
      bmp_pkg::ST_FINAL_MUL: state_d = bmp_pkg::ST_FINAL_WAIT;
      bmp_pkg::ST_FINAL_WAIT: begin
        if (sts_i.mul_done) state_d = bmp_pkg::ST_FINISH;
      end
      bmp_pkg::ST_FINISH: begin
        if (sts_i.out_free) state_d = bmp_pkg::ST_IDLE;
      end
      default: state_d = bmp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o        = '0;
    cmd_o.mul_op = bmp_pkg::MUL_FACT;
    unique case (state_q)
      bmp_pkg::ST_IDLE: begin
        cmd_o.in_ready = 1'b1;
        cmd_o.latch_in = in_valid_i;
      end
      bmp_pkg::ST_CHECK: begin
        if (sts_i.k_gt_n || sts_i.bad_query) cmd_o.load_err = 1'b1;
        else cmd_o.norm_init = 1'b1;
      end
      bmp_pkg::ST_NORM: begin
        cmd_o.norm_step = !sts_i.mnorm_top;
      end
      bmp_pkg::ST_DIV: cmd_o.div_step = 1'b1;
      bmp_pkg::ST_FACT_INIT: cmd_o.fact_init = 1'b1;
      bmp_pkg::ST_FACT_MUL: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_op    = bmp_pkg::MUL_FACT;
      end
      bmp_pkg::ST_FACT_WAIT: begin
        cmd_o.mul_wb = sts_i.mul_done;
        cmd_o.mul_op = bmp_pkg::MUL_FACT;
      end
      bmp_pkg::ST_DENOM_MUL: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_op    = bmp_pkg::MUL_DENOM;
      end
      bmp_pkg::ST_DENOM_WAIT: begin
        cmd_o.mul_wb = sts_i.mul_done;
        cmd_o.mul_op = bmp_pkg::MUL_DENOM;
      end
      bmp_pkg::ST_POW: begin
        cmd_o.mul_start = !sts_i.exp_zero && sts_i.exp_lsb;
        cmd_o.mul_op    = bmp_pkg::MUL_ACC;
      end
      bmp_pkg::ST_ACC_WAIT: begin
        cmd_o.mul_wb = sts_i.mul_done;
        cmd_o.mul_op = bmp_pkg::MUL_ACC;
      end
      bmp_pkg::ST_SQ_MUL: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_op    = bmp_pkg::MUL_SQ;
      end
      bmp_pkg::ST_SQ_WAIT: begin
        cmd_o.mul_wb = sts_i.mul_done;
        cmd_o.mul_op = bmp_pkg::MUL_SQ;
      end
      bmp_pkg::ST_FINAL_MUL: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_op    = bmp_pkg::MUL_FINAL;
      end
      bmp_pkg::ST_FINAL_WAIT: begin
        cmd_o.mul_wb = sts_i.mul_done;
        cmd_o.mul_op = bmp_pkg::MUL_FINAL;
      end
      bmp_pkg::ST_FINISH: cmd_o.out_load = sts_i.out_free;
      default: ;
    endcase
  end

endmodule

@@ hdl/bmp_modmul.sv @@
// Five-stage modular multiplier. The modulus is pre-normalized so that its top
// bit sits at bit 30; the product is shifted by the same amount, reduced by
// Barrett with mu = floor(2^62 / M), and shifted back at the end.
module bmp_modmul (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [bmp_pkg::MW-1:0]     a_i,
  input  logic [bmp_pkg::MW-1:0]     b_i,
  input  logic [bmp_pkg::MW-1:0]     mnorm_i,
  input  logic [bmp_pkg::SW-1:0]     shift_i,
  input  logic [bmp_pkg::MUW-1:0]    mu_i,
  output logic [bmp_pkg::MW-1:0]     res_o,
  output logic                       done_o,
  output logic                       busy_o
);

  logic [4:0]  vld_q, vld_d;
  logic [61:0] prod_q, prod_d;
  logic [61:0] xs_q, xs_d;
  logic [31:0] quo_q, quo_d;
  logic [33:0] xlo_q, xlo_d;
  logic [33:0] qm_q, qm_d;
  logic [32:0] rem_q, rem_d;
  logic [bmp_pkg::MW-1:0] res_q, res_d;

  logic [64:0] qmu;
  logic [62:0] qm_full;
  logic [33:0] diff;
  logic [32:0] m1, m2;
  logic [32:0] red;

  always_comb begin
    vld_d  = {vld_q[3:0], start_i};
    prod_d = 62'(a_i) * 62'(b_i);
    xs_d   = prod_q << shift_i;
    qmu    = 65'(xs_d[61:30]) * 65'(mu_i);
    quo_d  = qmu[63:32];
    qm_full = 63'(quo_q) * 63'(mnorm_i);
    qm_d   = qm_full[33:0];
    xlo_d  = xs_q[33:0];
    diff   = xlo_q - qm_q;
    rem_d  = diff[32:0];
    m1     = {2'b00, mnorm_i};
    m2     = {1'b0, mnorm_i, 1'b0};
    // The Barrett quotient is at most two short, so the remainder is below 3M.
    if (rem_q >= m2) red = rem_q - m2;
    else if (rem_q >= m1) red = rem_q - m1;
    else red = rem_q;
    res_d  = red[bmp_pkg::MW-1:0] >> shift_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    xs_q   <= xs_d;
    quo_q  <= quo_d;
    xlo_q  <= xlo_d;
    qm_q   <= qm_d;
    rem_q  <= rem_d;
    res_q  <= res_d;
  end

  assign res_o  = res_q;
  assign done_o = vld_q[4];
  assign busy_o = |vld_q;

endmodule

@@ hdl/bmp_dpath.sv @@
module bmp_dpath (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [bmp_pkg::MW-1:0]   cfg_wdata_i,
  input  logic [bmp_pkg::NW-1:0]   n_i,
  input  logic [bmp_pkg::NW-1:0]   k_i,
  input  bmp_pkg::cmd_t            cmd_i,
  output bmp_pkg::sts_t            sts_o,
  input  logic                     out_ready_i,
  output logic                     out_valid_o,
  output logic [bmp_pkg::MW-1:0]   out_coef_o,
  output logic                     out_flag_o
);

  logic [bmp_pkg::MW-1:0]  modulus_q, modulus_d;
  logic [bmp_pkg::NW-1:0]  n_q, n_d, k_q, k_d, i_q, i_d;
  logic [bmp_pkg::NW-1:0]  nk;
  logic [bmp_pkg::MW-1:0]  mnorm_q, mnorm_d;
  logic [bmp_pkg::SW-1:0]  shift_q, shift_d;
  logic [bmp_pkg::MW-1:0]  drem_q, drem_d;
  logic [bmp_pkg::DCW-1:0] dcnt_q, dcnt_d;
  logic [bmp_pkg::MUW-1:0] mu_q, mu_d;
  logic [bmp_pkg::MW-1:0]  fact_q, fact_d, fk_q, fk_d, fnk_q, fnk_d;
  logic [bmp_pkg::MW-1:0]  base_q, base_d, acc_q, acc_d, exp_q, exp_d;
  logic [bmp_pkg::MW-1:0]  coef_q, coef_d;
  logic                    flag_q, flag_d;
  logic                    oval_q, oval_d;
  logic [bmp_pkg::MW-1:0]  ocoef_q, ocoef_d;
  logic                    oflag_q, oflag_d;

  logic [31:0]             dtrial;
  logic                    dge;
  logic [bmp_pkg::MW-1:0]  op_a, op_b, mres;
  logic                    mdone, mbusy;

  assign nk = n_q - k_q;

  always_comb begin
    op_a = fact_q;
    op_b = fact_q;
    case (cmd_i.mul_op)
      bmp_pkg::MUL_FACT: begin
        op_a = {{(bmp_pkg::MW - bmp_pkg::NW){1'b0}}, i_q};
        op_b = fact_q;
      end
      bmp_pkg::MUL_DENOM: begin
        op_a = fk_q;
        op_b = fnk_q;
      end
      bmp_pkg::MUL_ACC: begin
        op_a = acc_q;
        op_b = base_q;
      end
      bmp_pkg::MUL_SQ: begin
        op_a = base_q;
        op_b = base_q;
      end
      bmp_pkg::MUL_FINAL: begin
        op_a = fact_q;
        op_b = acc_q;
      end
      default: ;
    endcase
  end

  bmp_modmul u_modmul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .a_i     (op_a),
    .b_i     (op_b),
    .mnorm_i (mnorm_q),
    .shift_i (shift_q),
    .mu_i    (mu_q),
    .res_o   (mres),
    .done_o  (mdone),
    .busy_o  (mbusy)
  );

  // One restoring step of floor(2^62 / M); the dividend has its only set bit first.
  assign dtrial = {drem_q, (dcnt_q == '0)};
  assign dge    = dtrial >= {1'b0, mnorm_q};

  always_comb begin
    modulus_d = modulus_q;
    n_d = n_q;  k_d = k_q;  i_d = i_q;
    mnorm_d = mnorm_q;  shift_d = shift_q;
    drem_d = drem_q;  dcnt_d = dcnt_q;  mu_d = mu_q;
    fact_d = fact_q;  fk_d = fk_q;  fnk_d = fnk_q;
    base_d = base_q;  acc_d = acc_q;  exp_d = exp_q;
    coef_d = coef_q;  flag_d = flag_q;
    ocoef_d = ocoef_q;  oflag_d = oflag_q;
    oval_d = oval_q;

    if (cfg_we_i) modulus_d = cfg_wdata_i;

    if (cmd_i.latch_in) begin
      n_d = n_i;
      k_d = k_i;
    end
    if (cmd_i.load_err) begin
      coef_d = '0;
      flag_d = n_q < k_q;
    end
    if (cmd_i.norm_init) begin
      mnorm_d = modulus_q;
      shift_d = '0;
      drem_d  = '0;
      dcnt_d  = '0;
      mu_d    = '0;
    end
    if (cmd_i.norm_step) begin
      mnorm_d = {mnorm_q[bmp_pkg::MW-2:0], 1'b0};
      shift_d = shift_q + 5'd1;
    end
    if (cmd_i.div_step) begin
      drem_d = dge ? 31'(dtrial - {1'b0, mnorm_q}) : dtrial[bmp_pkg::MW-1:0];
      mu_d   = {mu_q[bmp_pkg::MUW-2:0], dge};
      dcnt_d = dcnt_q + 6'd1;
    end
    if (cmd_i.fact_init) begin
      fact_d = 31'd1;
      fk_d   = 31'd1;
      fnk_d  = 31'd1;
      i_d    = 20'd1;
    end
    if (cmd_i.mul_wb) begin
      case (cmd_i.mul_op)
        bmp_pkg::MUL_FACT: begin
          fact_d = mres;
          if (i_q == k_q) fk_d = mres;
          if (i_q == nk) fnk_d = mres;
          i_d = i_q + 20'd1;
        end
        bmp_pkg::MUL_DENOM: begin
          base_d = mres;
          acc_d  = 31'd1;
          exp_d  = modulus_q - 31'd2;
        end
        bmp_pkg::MUL_ACC: acc_d = mres;
        bmp_pkg::MUL_SQ: begin
          base_d = mres;
          exp_d  = exp_q >> 1;
        end
        bmp_pkg::MUL_FINAL: begin
          coef_d = mres;
          flag_d = 1'b0;
        end
        default: ;
      endcase
    end

    if (cmd_i.out_load) begin
      oval_d  = 1'b1;
      ocoef_d = coef_q;
      oflag_d = flag_q;
    end else if (out_ready_i) begin
      oval_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= bmp_pkg::MODULUS_RESET;
      oval_q    <= 1'b0;
    end else begin
      modulus_q <= modulus_d;
      oval_q    <= oval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d;  k_q <= k_d;  i_q <= i_d;
    mnorm_q <= mnorm_d;  shift_q <= shift_d;
    drem_q <= drem_d;  dcnt_q <= dcnt_d;  mu_q <= mu_d;
    fact_q <= fact_d;  fk_q <= fk_d;  fnk_q <= fnk_d;
    base_q <= base_d;  acc_q <= acc_d;  exp_q <= exp_d;
    coef_q <= coef_d;  flag_q <= flag_d;
    ocoef_q <= ocoef_d;  oflag_q <= oflag_d;
  end

  always_comb begin
    sts_o.k_gt_n    = k_q > n_q;
    sts_o.bad_query = ({4'b0000, n_q} > bmp_pkg::MAX_N) || (modulus_q < 31'd2);
    sts_o.mnorm_top = mnorm_q[bmp_pkg::MW-1];
    sts_o.div_last  = dcnt_q == bmp_pkg::DIV_LAST;
    sts_o.n_zero    = n_q == '0;
    sts_o.i_last    = i_q == n_q;
    sts_o.mul_busy  = mbusy;
    sts_o.mul_done  = mdone;
    sts_o.exp_zero  = exp_q == '0;
    sts_o.exp_lsb   = exp_q[0];
    sts_o.out_free  = !oval_q || out_ready_i;
  end

  assign out_valid_o = oval_q;
  assign out_coef_o  = ocoef_q;
  assign out_flag_o  = oflag_q;

endmodule

@@ hdl/binomial_mod_prime.sv @@
// Channel   Dir  Fields (lowest bit up)                      Beat on
// s_axis    in   tdata: n_value[19:0], k_value[39:20]         tvalid & tready
// m_axis    out  tdata: coefficient[30:0]; tuser: k_exceeds_n tvalid & tready
// cfg       in   cfg_wdata_i: modulus[30:0]                   cfg_we_i
//
// A query holds the block from its accept cycle until its result enters the output register:
// it is checked, the modulus is normalized and its Barrett reciprocal formed one bit per cycle,
// each factorial step takes one pass of the 5-stage modular multiplier, and then follow the
// denominator, the exponentiation, the final product and the hand-off.
// Queries with k above n, n above the limit or a modulus below two skip the arithmetic.
// Reset clears the controller, the output beat and sets the modulus to 1000000007.
// A result waits in the output register; a new beat is taken once the block is idle.
module binomial_mod_prime (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [30:0] cfg_wdata_i,   // modulus
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // n_value[19:0], k_value[39:20]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // coefficient[30:0], zero[31]
  output logic        m_axis_tuser   // k_exceeds_n
);

  bmp_pkg::cmd_t cmd;
  bmp_pkg::sts_t sts;
  logic [bmp_pkg::MW-1:0] coef;

  bmp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bmp_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .n_i         (s_axis_tdata[19:0]),
    .k_i         (s_axis_tdata[39:20]),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_coef_o  (coef),
    .out_flag_o  (m_axis_tuser)
  );

  assign s_axis_tready = cmd.in_ready;
  assign m_axis_tdata  = {1'b0, coef};

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> sts.out_free)
    else $error("result loaded while the output beat is still held");

  a_mul_not_overlapped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.mul_start |-> !sts.mul_busy)
    else $error("multiplier started while a product is in flight");

  a_flag_zero_coef: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == 32'd0))
    else $error("k above n delivered with a nonzero coefficient");

  a_one_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second input beat taken while a query is running");

endmodule

@@ tb/binomial_mod_prime_tb.sv @@
module binomial_mod_prime_tb;

  localparam int unsigned CYCLE_LIMIT = 2500000;
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned LONG_HOLD = 4000;
  localparam logic [30:0] MODULUS_MAX = 31'h7FFFFFFF;

  typedef struct packed {
    logic [bmp_pkg::NW-1:0] n_value;
    logic [bmp_pkg::NW-1:0] k_value;
  } query_t;

  typedef struct packed {
    logic [bmp_pkg::NW-1:0] n_value;
    logic [bmp_pkg::NW-1:0] k_value;
    logic [bmp_pkg::MW-1:0] coefficient;
    logic                   k_exceeds_n;
  } coef_t;

  typedef enum logic [1:0] {
    RX_STREAM,
    RX_COIN,
    RX_SPARSE,
    RX_TOGGLE
  } rx_mode_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [30:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;   // n_value[19:0], k_value[39:20]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // coefficient[30:0], zero[31]
  logic        m_axis_tuser;        // k_exceeds_n

  query_t      pending_queries[$];
  coef_t       expected_coefs[$];
  logic [30:0] modulus_copy = bmp_pkg::MODULUS_RESET;
  logic        in_beat = 1'b0;
  int unsigned mismatch_count = 0;
  int unsigned results_seen = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;
  rx_mode_e    rx_mode = RX_STREAM;
  int unsigned rx_mode_left = 0;

  binomial_mod_prime uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // base^exp mod m with the exponent scanned from its least significant bit.
  function automatic longint unsigned fermat_power(input longint unsigned base,
                                                   input longint unsigned exp,
                                                   input longint unsigned m);
    longint unsigned acc;
    longint unsigned b;
    longint unsigned e;
    acc = 1 % m;
    b = base % m;
    e = exp;
    while (e != 0) begin
      if (e[0]) begin
        acc = (acc * b) % m;
      end
      b = (b * b) % m;
      e = e >> 1;
    end
    return acc;
  endfunction

  function automatic coef_t binomial_mod(input logic [19:0] n_value,
                                         input logic [19:0] k_value,
                                         input logic [30:0] m_value);
    coef_t           r;
    longint unsigned n;
    longint unsigned k;
    longint unsigned m;
    longint unsigned fact;
    longint unsigned fk;
    longint unsigned fnk;
    longint unsigned i;
    longint unsigned denom;
    longint unsigned inv;
    r = '0;
    r.n_value = n_value;
    r.k_value = k_value;
    n = 64'(n_value);
    k = 64'(k_value);
    m = 64'(m_value);
    if (k > n) begin
      r.k_exceeds_n = 1'b1;
      return r;
    end
    if (n > 64'(bmp_pkg::MAX_N) || m < 2) begin
      return r;
    end
    fact = 1 % m;
    fk = fact;
    fnk = fact;
    for (i = 1; i <= n; i++) begin
      fact = (i * fact) % m;
      if (i == k) begin
        fk = fact;
      end
      if (i == n - k) begin
        fnk = fact;
      end
    end
    denom = (fk * fnk) % m;
    inv = fermat_power(denom, m - 2, m);
    r.coefficient = 31'(((fact % m) * inv) % m);
    return r;
  endfunction

  // Mostly well-formed queries of modest size; full-range n only where the
  // block answers at once.
  function automatic query_t random_query(input bit any_size);
    query_t q;
    if ($urandom_range(0, 7) == 0) begin
      q.n_value = 20'($urandom_range(0, 20'hFFFFE));
      q.k_value = 20'($urandom_range(32'(q.n_value) + 1, 20'hFFFFF));
    end else begin
      if (any_size) begin
        q.n_value = 20'($urandom());
      end else if ($urandom_range(0, 15) == 0) begin
        q.n_value = 20'($urandom_range(128, 1023));
      end else begin
        q.n_value = 20'($urandom_range(0, 127));
      end
      q.k_value = 20'($urandom_range(0, 32'(q.n_value)));
    end
    return q;
  endfunction

  task automatic add_query(input logic [19:0] n_value, input logic [19:0] k_value);
    query_t q;
    q.n_value = n_value;
    q.k_value = k_value;
    pending_queries.insert(pending_queries.size(), q);
  endtask

  task automatic add_random(input int unsigned count, input bit any_size);
    repeat (count) pending_queries.insert(pending_queries.size(), random_query(any_size));
  endtask

  task automatic wait_all_done();
    do @(posedge clk_i);
    while (pending_queries.size() != 0 || s_axis_tvalid || expected_coefs.size() != 0);
  endtask

  task automatic write_modulus(input logic [30:0] value);
    wait_all_done();
    @(negedge clk_i);
    cfg_wdata_i <= value;
    cfg_we_i <= 1'b1;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset modulus: small cases, both field extremes and k above n.
    add_query(20'd0, 20'd0);
    add_query(20'd1, 20'd0);
    add_query(20'd1, 20'd1);
    add_query(20'd5, 20'd2);
    add_query(20'd20, 20'd20);
    add_query(20'd20, 20'd0);
    add_query(20'd127, 20'd63);
    add_query(20'd1000, 20'd500);
    add_query(20'd0, 20'd1);
    add_query(20'd3, 20'hFFFFF);
    add_query(20'hFFFFE, 20'hFFFFF);

    write_modulus(MODULUS_MAX);
    add_query(20'd1000, 20'd1);
    add_query(20'd12, 20'd6);
    add_random(20, 1'b0);

    // Exponent of zero makes the inverse one.
    write_modulus(31'd2);
    add_query(20'd1, 20'd1);
    add_query(20'd4, 20'd2);
    add_query(20'd5, 20'd2);
    add_random(10, 1'b0);

    // n at or above a small prime drives the factorial to zero.
    write_modulus(31'd13);
    add_query(20'd12, 20'd6);
    add_query(20'd13, 20'd6);
    add_query(20'd26, 20'd13);
    add_random(10, 1'b0);

    // Moduli below two answer at once, so n may use its whole range here.
    write_modulus(31'd0);
    add_query(20'hFFFFF, 20'd0);
    add_query(20'hFFFFF, 20'hFFFFF);
    add_query(20'hFFFFF, 20'h80000);
    add_random(10, 1'b1);

    write_modulus(31'd1);
    add_query(20'hFFFFF, 20'hAAAAA);
    add_query(20'd5, 20'd2);
    add_random(10, 1'b1);

    // A composite modulus runs the same arithmetic.
    write_modulus(31'd12);
    add_query(20'd6, 20'd2);
    add_query(20'd4, 20'd1);
    add_random(10, 1'b0);

    write_modulus(bmp_pkg::MODULUS_RESET);
    add_random(10, 1'b0);

    wait_all_done();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && expected_coefs.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("FAILURE");
    $finish;
  end

  always @(negedge clk_i) begin : drive_queries
    query_t q;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_beat) begin
      if (gap_left != 0) begin
        s_axis_tvalid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_queries.size() != 0) begin
        q = pending_queries.pop_front();
        s_axis_tdata <= {q.k_value, q.n_value};
        s_axis_tvalid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 8);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // The long hold lets the output register fill while queries keep coming.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen >= 20 && pending_queries.size() > 4) begin
      m_axis_tready <= 1'b0;
      hold_left <= LONG_HOLD;
      hold_done <= 1'b1;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode <= rx_mode_e'($urandom_range(0, 3));
        rx_mode_left <= $urandom_range(1, 64);
      end else begin
        rx_mode_left <= rx_mode_left - 1;
      end
      case (rx_mode)
        RX_STREAM: m_axis_tready <= 1'b1;
        RX_COIN:   m_axis_tready <= ($urandom_range(0, 1) == 1);
        RX_SPARSE: m_axis_tready <= ($urandom_range(0, 7) == 0);
        default:   m_axis_tready <= ~m_axis_tready;
      endcase
    end
  end

  always @(posedge clk_i) begin : check_results
    coef_t want;
    if (rst_ni) begin
      if (cfg_we_i) begin
        modulus_copy = cfg_wdata_i;
      end
      in_beat <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        expected_coefs.insert(expected_coefs.size(),
                              binomial_mod(s_axis_tdata[19:0], s_axis_tdata[39:20],
                                           modulus_copy));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (expected_coefs.size() == 0) begin
          $error("unexpected result beat: coefficient %0d k_exceeds_n %0d",
                 m_axis_tdata[30:0], m_axis_tuser);
          mismatch_count++;
        end else begin
          want = expected_coefs.pop_front();
          if (m_axis_tdata[30:0] !== want.coefficient) begin
            $error("coefficient: expected %0d, actual %0d (n=%0d k=%0d)",
                   want.coefficient, m_axis_tdata[30:0], want.n_value, want.k_value);
            mismatch_count++;
          end
          if (m_axis_tuser !== want.k_exceeds_n) begin
            $error("k_exceeds_n: expected %0d, actual %0d (n=%0d k=%0d)",
                   want.k_exceeds_n, m_axis_tuser, want.n_value, want.k_value);
            mismatch_count++;
          end
        end
      end
    end
  end

endmodule
